// File: sv/psdb_pkg.sv
// ---------------------------------------------------------------------------
// psdb_pkg
// Shared types, codes and helpers of the point splat depth buffer.
// ---------------------------------------------------------------------------
package psdb_pkg;

  localparam int DEF_MAP_WIDTH  = 64;
  localparam int DEF_MAP_HEIGHT = 64;
  localparam int DEF_COORD_BITS = 32;

  // covers map sizes up to 2047 plus the exclusive bound
  localparam int LIM_W    = 11;
  localparam int ENTRY_W  = 12;
  localparam int QDEPTH   = 2;

  localparam logic [1:0] MODE_SPLAT = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_ZERO  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam logic [2:0] REG_FOCAL_X  = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] REG_CENTER_X = 3'd2;
  localparam logic [2:0] REG_CENTER_Y = 3'd3;
  localparam logic [2:0] REG_VOXEL    = 3'd4;
  localparam logic [2:0] REG_ACT_W    = 3'd5;
  localparam logic [2:0] REG_ACT_H    = 3'd6;

  localparam logic [31:0] RST_FOCAL  = 32'd4194304;
  localparam logic [31:0] RST_CENTER = 32'd2129920;
  localparam logic [6:0]  RST_ACTIVE = 7'd64;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        vox;
    logic [6:0]         aw;
    logic [6:0]         ah;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic               zdrop;
    logic [31:0]        x;
    logic [31:0]        y;
    logic [31:0]        z;
    logic [LIM_W-1:0]   x0;
    logic [LIM_W-1:0]   x1;
    logic [LIM_W-1:0]   y0;
    logic [LIM_W-1:0]   y1;
    logic [ENTRY_W-1:0] entry;
  } job_t;

  function automatic logic [LIM_W-1:0] clamp_px(logic signed [63:0] p,
                                                logic [LIM_W-1:0] lim);
    logic signed [63:0] lim64;
    lim64 = $signed({{(64-LIM_W){1'b0}}, lim});
    if (p < 0) return '0;
    else if (p > lim64) return lim;
    else return p[LIM_W-1:0];
  endfunction

endpackage

// File: sv/psdb_front.sv
// ---------------------------------------------------------------------------
// psdb_front
// Takes commands, projects splat corners through a shared multiplier and
// a radix-2 divider, clamps them to the map and queues the finished job.
// ---------------------------------------------------------------------------
module psdb_front #(
  parameter int MAP_WIDTH  = psdb_pkg::DEF_MAP_WIDTH,
  parameter int MAP_HEIGHT = psdb_pkg::DEF_MAP_HEIGHT,
  parameter int COORD_BITS = psdb_pkg::DEF_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [1:0]                    mode,
  input  logic [31:0]                   coord_x,
  input  logic [31:0]                   coord_y,
  input  logic [31:0]                   coord_z,
  input  logic [psdb_pkg::ENTRY_W-1:0]  entry_index,
  input  psdb_pkg::cfg_t                cfg,
  input  logic                          q_full,
  output logic                          q_push,
  output psdb_pkg::job_t                q_job,
  output logic                          idle
);

  localparam int LW = psdb_pkg::LIM_W;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_ABS  = 3'd2;
  localparam logic [2:0] F_DIV  = 3'd3;
  localparam logic [2:0] F_FIN  = 3'd4;
  localparam logic [2:0] F_CLP  = 3'd5;
  localparam logic [2:0] F_PUSH = 3'd6;

  logic [2:0]         state;
  logic [1:0]         jmode;
  logic               jzero;
  logic signed [31:0] px, py, pz, xs, ys;
  logic [psdb_pkg::ENTRY_W-1:0] entry;
  logic [1:0]         k;
  logic signed [63:0] prod, ssum;
  logic [63:0]        quo;
  logic [31:0]        rem, dvs;
  logic               neg;
  logic [5:0]         dcnt;
  logic [LW-1:0]      xa, xb, ya, yb;

  logic signed [31:0] x_in, y_in, z_in, fsel, csel, asel;
  logic signed [33:0] xsum, ysum;
  logic signed [63:0] pr, pr1;
  logic [32:0]        shifted;
  logic               ge;
  logic [LW-1:0]      aw_lim, ah_lim, lim, cl, cl1;
  logic               last_proj;

  assign x_in = 32'($signed(coord_x[COORD_BITS-1:0]));
  assign y_in = 32'($signed(coord_y[COORD_BITS-1:0]));
  assign z_in = 32'($signed(coord_z[COORD_BITS-1:0]));
  assign xsum = 34'(x_in) + $signed({3'b000, cfg.vox});
  assign ysum = 34'(y_in) + $signed({3'b000, cfg.vox});

  always_comb begin
    fsel = k[0] ? cfg.fy : cfg.fx;
    csel = k[0] ? cfg.cy : cfg.cx;
    case (k)
      2'd0:    asel = px;
      2'd1:    asel = py;
      2'd2:    asel = xs;
      default: asel = ys;
    endcase
  end

  assign shifted = {rem, quo[63]};
  assign ge      = shifted >= {1'b0, dvs};

  // truncate toward zero on the divide by 2^16
  assign pr  = ssum[63] ? ((ssum + 64'sd65535) >>> 16) : (ssum >>> 16);
  assign pr1 = pr + 64'sd1;

  assign aw_lim = (LW'(cfg.aw) > LW'(MAP_WIDTH))  ? LW'(MAP_WIDTH)  : LW'(cfg.aw);
  assign ah_lim = (LW'(cfg.ah) > LW'(MAP_HEIGHT)) ? LW'(MAP_HEIGHT) : LW'(cfg.ah);
  assign lim    = k[0] ? ah_lim : aw_lim;
  assign cl     = psdb_pkg::clamp_px(pr, lim);
  assign cl1    = psdb_pkg::clamp_px(pr1, lim);
  assign last_proj = (k == 2'd3) || (k == 2'd1 && cfg.vox == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            jmode <= mode;
            jzero <= (mode == psdb_pkg::MODE_SPLAT) && (z_in == '0);
            px    <= x_in;
            py    <= y_in;
            pz    <= z_in;
            xs    <= (xsum > 34'sd2147483647) ? 32'sh7FFFFFFF : xsum[31:0];
            ys    <= (ysum > 34'sd2147483647) ? 32'sh7FFFFFFF : ysum[31:0];
            entry <= entry_index;
            k     <= 2'd0;
            state <= (mode == psdb_pkg::MODE_SPLAT && z_in != '0) ? F_MUL : F_PUSH;
          end
        end
        F_MUL: begin
          prod  <= fsel * asel;
          state <= F_ABS;
        end
        F_ABS: begin
          quo   <= prod[63] ? 64'(-prod) : 64'(prod);
          dvs   <= pz[31] ? 32'(-pz) : 32'(pz);
          neg   <= prod[63] ^ pz[31];
          rem   <= '0;
          dcnt  <= '0;
          state <= F_DIV;
        end
        F_DIV: begin
          rem   <= ge ? 32'(shifted - {1'b0, dvs}) : shifted[31:0];
          quo   <= {quo[62:0], ge};
          dcnt  <= dcnt + 6'd1;
          if (dcnt == 6'd63) state <= F_FIN;
        end
        F_FIN: begin
          ssum  <= (neg ? -$signed(quo) : $signed(quo)) + 64'(csel);
          state <= F_CLP;
        end
        F_CLP: begin
          case (k)
            2'd0:    begin xa <= cl; xb <= cl1; end
            2'd1:    begin ya <= cl; yb <= cl1; end
            2'd2:    xb <= cl;
            default: yb <= cl;
          endcase
          if (last_proj) begin
            state <= F_PUSH;
          end else begin
            k     <= k + 2'd1;
            state <= F_MUL;
          end
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign idle   = (state == F_IDLE);
  assign q_push = (state == F_PUSH) && !q_full;

  always_comb begin
    q_job.mode  = jmode;
    q_job.zdrop = jzero;
    q_job.x     = px;
    q_job.y     = py;
    q_job.z     = pz;
    q_job.x0    = (xa < xb) ? xa : xb;
    q_job.x1    = (xa < xb) ? xb : xa;
    q_job.y0    = (ya < yb) ? ya : yb;
    q_job.y1    = (ya < yb) ? yb : ya;
    q_job.entry = entry;
  end

endmodule

// File: sv/psdb_queue.sv
// ---------------------------------------------------------------------------
// psdb_queue
// Short job queue between the projection front and the map engine.
// ---------------------------------------------------------------------------
module psdb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  psdb_pkg::job_t din,
  input  logic           pop,
  output psdb_pkg::job_t dout,
  output logic           full,
  output logic           empty
);

  localparam int D  = psdb_pkg::QDEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  psdb_pkg::job_t slots [D];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  cnt;

  assign full  = (cnt == CW'(D));
  assign empty = (cnt == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(D - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(D - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

endmodule

// File: sv/psdb_back.sv
// ---------------------------------------------------------------------------
// psdb_back
// Map engine: walks splat footprints with read-compare-write on the point
// store, keeps the first-touch list, serves list reads and clear sweeps.
// ---------------------------------------------------------------------------
module psdb_back #(
  parameter int MAP_WIDTH  = psdb_pkg::DEF_MAP_WIDTH,
  parameter int MAP_HEIGHT = psdb_pkg::DEF_MAP_HEIGHT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  psdb_pkg::job_t q_job,
  output logic           q_pop,
  output logic           init_busy,
  output logic           done,
  output logic [5:0]     pixel_col,
  output logic [5:0]     pixel_row,
  output logic [31:0]    stored_x,
  output logic [31:0]    stored_y,
  output logic [31:0]    stored_z,
  output logic [12:0]    touched_count,
  output logic [12:0]    pixels_written,
  output logic [1:0]     status
);

  localparam int LW        = psdb_pkg::LIM_W;
  localparam int MAP_CELLS = MAP_WIDTH * MAP_HEIGHT;
  localparam int CELL_W    = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
  localparam int CNT_W     = $clog2(MAP_CELLS + 1);
  localparam int COL_W     = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1;
  localparam int ROW_W     = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;

  localparam logic [2:0] B_INIT = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_RD   = 3'd2;
  localparam logic [2:0] B_CMP  = 3'd3;
  localparam logic [2:0] B_TL   = 3'd4;
  localparam logic [2:0] B_TL2  = 3'd5;
  localparam logic [2:0] B_DAT  = 3'd6;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  typedef struct packed {
    logic [5:0]  col;
    logic [5:0]  row;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [12:0] touched;
    logic [12:0] written;
    logic [1:0]  status;
  } res_t;

  // result with no pixel data
  function automatic res_t brief_res(logic [CNT_W-1:0] touched,
                                     logic [CNT_W-1:0] wr,
                                     logic [1:0]       st);
    res_t r;
    r         = '0;
    r.touched = 13'(touched);
    r.written = 13'(wr);
    r.status  = st;
    return r;
  endfunction

  point_t                   pmem [MAP_CELLS];
  logic [ROW_W+COL_W-1:0]   tmem [MAP_CELLS];

  logic [2:0]               state;
  psdb_pkg::job_t           job;
  logic [LW-1:0]            px, py;
  logic [CNT_W-1:0]         written, count;
  logic [CELL_W-1:0]        clr_addr;
  logic                     clr_cmd;
  point_t                   pm_q;
  logic [ROW_W+COL_W-1:0]   tl_q;
  res_t                     res;

  logic [CELL_W-1:0]        walk_addr, tl_addr, rd_addr, pm_waddr;
  point_t                   pm_wdata;
  logic                     pm_we, tl_we, empty_ent, hit, last_py, last_px;
  logic [CNT_W-1:0]         count_next, written_next;

  assign walk_addr = CELL_W'(py) * CELL_W'(MAP_WIDTH) + CELL_W'(px);
  assign tl_addr   = CELL_W'(tl_q[COL_W +: ROW_W]) * CELL_W'(MAP_WIDTH)
                   + CELL_W'(tl_q[COL_W-1:0]);
  assign rd_addr   = (state == B_TL2) ? tl_addr : walk_addr;

  // an empty entry is all zero; a stored point never has zero depth
  assign empty_ent = (pm_q == '0);
  assign hit       = empty_ent || ($signed(job.z) > $signed(pm_q.z));
  assign pm_we     = (state == B_INIT) || (state == B_CMP && hit);
  assign pm_waddr  = (state == B_INIT) ? clr_addr : walk_addr;
  assign pm_wdata  = (state == B_INIT) ? '0 : {job.x, job.y, job.z};
  assign tl_we     = (state == B_CMP) && empty_ent && (count < CNT_W'(MAP_CELLS));

  assign count_next   = tl_we ? count + 1'b1 : count;
  assign written_next = hit ? written + 1'b1 : written;
  assign last_py      = (py + 1'b1) == job.y1;
  assign last_px      = (px + 1'b1) == job.x1;

  always_ff @(posedge clk) begin
    if (pm_we) pmem[pm_waddr] <= pm_wdata;
    pm_q <= pmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (tl_we) tmem[CELL_W'(count)] <= {ROW_W'(py), COL_W'(px)};
    tl_q <= tmem[CELL_W'(job.entry)];
  end

  assign q_pop     = (state == B_IDLE) && !q_empty;
  assign init_busy = (state == B_INIT) && !clr_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_INIT;
      clr_addr <= '0;
      clr_cmd  <= 1'b0;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        B_INIT: begin
          if (clr_addr == CELL_W'(MAP_CELLS - 1)) begin
            clr_addr <= '0;
            state    <= B_IDLE;
            if (clr_cmd) begin
              clr_cmd <= 1'b0;
              done    <= 1'b1;
              res     <= brief_res(count, '0, psdb_pkg::STAT_OK);
            end
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        B_IDLE: begin
          if (!q_empty) begin
            job <= q_job;
            unique case (q_job.mode)
              psdb_pkg::MODE_SPLAT: begin
                if (q_job.zdrop) begin
                  done <= 1'b1;
                  res  <= brief_res(count, '0, psdb_pkg::STAT_ZERO);
                end else if (q_job.x0 < q_job.x1 && q_job.y0 < q_job.y1) begin
                  px      <= q_job.x0;
                  py      <= q_job.y0;
                  written <= '0;
                  state   <= B_RD;
                end else begin
                  done <= 1'b1;
                  res  <= brief_res(count, '0, psdb_pkg::STAT_OK);
                end
              end
              psdb_pkg::MODE_READ: begin
                if (32'(q_job.entry) < 32'(count)) begin
                  state <= B_TL;
                end else begin
                  done <= 1'b1;
                  res  <= brief_res(count, '0, psdb_pkg::STAT_RANGE);
                end
              end
              psdb_pkg::MODE_CLEAR: begin
                count   <= '0;
                clr_cmd <= 1'b1;
                state   <= B_INIT;
              end
              default: begin
                done <= 1'b1;
                res  <= brief_res(count, '0, psdb_pkg::STAT_OK);
              end
            endcase
          end
        end
        B_RD: state <= B_CMP;
        B_CMP: begin
          count   <= count_next;
          written <= written_next;
          if (!last_py) begin
            py    <= py + 1'b1;
            state <= B_RD;
          end else if (!last_px) begin
            px    <= px + 1'b1;
            py    <= job.y0;
            state <= B_RD;
          end else begin
            state <= B_IDLE;
            done  <= 1'b1;
            res   <= brief_res(count_next, written_next, psdb_pkg::STAT_OK);
          end
        end
        B_TL:  state <= B_TL2;
        B_TL2: state <= B_DAT;
        B_DAT: begin
          state <= B_IDLE;
          done  <= 1'b1;
          res   <= res_t'{col:     6'(tl_q[COL_W-1:0]),
                          row:     6'(tl_q[COL_W +: ROW_W]),
                          x:       pm_q.x,
                          y:       pm_q.y,
                          z:       pm_q.z,
                          touched: 13'(count),
                          written: '0,
                          status:  psdb_pkg::STAT_OK};
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign pixel_col      = res.col;
  assign pixel_row      = res.row;
  assign stored_x       = res.x;
  assign stored_y       = res.y;
  assign stored_z       = res.z;
  assign touched_count  = res.touched;
  assign pixels_written = res.written;
  assign status         = res.status;

endmodule

// File: sv/point_splat_depth_buffer_unit.sv
// Splat: projects x and y, and also the far corner with a voxel size set,
//   then a read and a compare-write per covered in-map pixel in the map engine.
// Read: list entry, then point store. Clear: sweeps the point store, one entry a cycle.
// The 64-step divider sets the projection time; a new command is taken once
// the front has queued the previous one and the reset sweep is done. Results cannot be stalled.
// Reset: clears registers, then sweeps the point store while busy.
// ---------------------------------------------------------------------------
// point_splat_depth_buffer_unit
// Z-buffered point splatting onto a pixel map with a first-touch list.
// ---------------------------------------------------------------------------
module point_splat_depth_buffer_unit #(
  parameter int MAP_WIDTH  = psdb_pkg::DEF_MAP_WIDTH,
  parameter int MAP_HEIGHT = psdb_pkg::DEF_MAP_HEIGHT,
  parameter int COORD_BITS = psdb_pkg::DEF_COORD_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] coord_z,
  input  logic [11:0] entry_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [5:0]  pixel_col,
  output logic [5:0]  pixel_row,
  output logic [31:0] stored_x,
  output logic [31:0] stored_y,
  output logic [31:0] stored_z,
  output logic [12:0] touched_count,
  output logic [12:0] pixels_written,
  output logic [1:0]  status
);

  psdb_pkg::cfg_t cfg;
  psdb_pkg::job_t push_job, pop_job;
  logic           front_idle, init_busy, q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;
  assign busy      = !front_idle || init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fx  <= psdb_pkg::RST_FOCAL;
      cfg.fy  <= psdb_pkg::RST_FOCAL;
      cfg.cx  <= psdb_pkg::RST_CENTER;
      cfg.cy  <= psdb_pkg::RST_CENTER;
      cfg.vox <= '0;
      cfg.aw  <= psdb_pkg::RST_ACTIVE;
      cfg.ah  <= psdb_pkg::RST_ACTIVE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        psdb_pkg::REG_FOCAL_X:  cfg.fx  <= cfg_data;
        psdb_pkg::REG_FOCAL_Y:  cfg.fy  <= cfg_data;
        psdb_pkg::REG_CENTER_X: cfg.cx  <= cfg_data;
        psdb_pkg::REG_CENTER_Y: cfg.cy  <= cfg_data;
        psdb_pkg::REG_VOXEL:    cfg.vox <= cfg_data[30:0];
        psdb_pkg::REG_ACT_W:    cfg.aw  <= cfg_data[6:0];
        psdb_pkg::REG_ACT_H:    cfg.ah  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  psdb_front #(
    .MAP_WIDTH (MAP_WIDTH),
    .MAP_HEIGHT(MAP_HEIGHT),
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (start && !busy),
    .mode       (mode),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .entry_index(entry_index),
    .cfg        (cfg),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job),
    .idle       (front_idle)
  );

  psdb_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (push_job),
    .pop  (q_pop),
    .dout (pop_job),
    .full (q_full),
    .empty(q_empty)
  );

  psdb_back #(
    .MAP_WIDTH (MAP_WIDTH),
    .MAP_HEIGHT(MAP_HEIGHT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_job         (pop_job),
    .q_pop         (q_pop),
    .init_busy     (init_busy),
    .done          (done),
    .pixel_col     (pixel_col),
    .pixel_row     (pixel_row),
    .stored_x      (stored_x),
    .stored_y      (stored_y),
    .stored_z      (stored_z),
    .touched_count (touched_count),
    .pixels_written(pixels_written),
    .status        (status)
  );

endmodule

// File: sv/psdb_checker.sv
// ---------------------------------------------------------------------------
// psdb_checker
// Port-level checks of the point splat depth buffer.
// ---------------------------------------------------------------------------
module psdb_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [5:0]  pixel_col,
  input logic [5:0]  pixel_row,
  input logic [31:0] stored_x,
  input logic [31:0] stored_y,
  input logic [31:0] stored_z,
  input logic [12:0] pixels_written,
  input logic [1:0]  status
);

  // an accepted transaction takes the front out of idle and so raises busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after accepted transaction");

  a_no_done_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe right after reset");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == psdb_pkg::STAT_RANGE) |->
      (stored_x == '0 && stored_y == '0 && stored_z == '0 &&
       pixel_col == '0 && pixel_row == '0 && pixels_written == '0))
    else $error("out-of-range read returned data");

  a_zero_depth: assert property (@(posedge clk) disable iff (rst)
    (done && status == psdb_pkg::STAT_ZERO) |-> (pixels_written == '0))
    else $error("zero-depth splat reported written pixels");

endmodule

bind point_splat_depth_buffer_unit psdb_checker u_psdb_checker (.*);
